// ===== hw/rtl/pccms_pkg.sv =====
// Shared widths, coefficient table, register codes and saturation helper for the converter step.
package pccms_pkg;

  localparam int DW        = 32;
  localparam int FracBits  = 16;
  localparam int GainW     = 24;
  localparam int LimW      = 31;
  localparam int CoefW     = 18;
  localparam int OpBW      = GainW + 1;
  localparam int ProdW     = DW + OpBW;
  localparam int RndW      = ProdW - FracBits;
  localparam int AccW      = 48;
  localparam int NumStates = 6;
  localparam int IdxW      = 3;

  localparam logic [IdxW-1:0] LastRow  = IdxW'(NumStates - 1);
  localparam logic [IdxW-1:0] DriveCol = IdxW'(NumStates);

  localparam logic [GainW-1:0] KpReset  = GainW'(65536);
  localparam logic [GainW-1:0] KiReset  = GainW'(6554);
  localparam logic [LimW-1:0]  IlReset  = LimW'(655360);
  localparam logic [LimW-1:0]  DlReset  = LimW'(655360);

  typedef enum logic [1:0] {
    CfgKp = 2'd0,
    CfgKi = 2'd1,
    CfgIntLimit = 2'd2,
    CfgDriveLimit = 2'd3
  } cfg_idx_e;

  // Row r gives new state r from (i1, u1, i2, u2, i3, u3, drive), Q2.16.
  localparam logic signed [CoefW-1:0] COEF [NumStates][NumStates+1] = '{
    '{ 18'sd63255, -18'sd1127,   18'sd374,   -18'sd380,    18'sd341,  -18'sd1645,  18'sd3087 },
    '{ 18'sd50672,  18'sd8205,   18'sd15172,  18'sd4588,   18'sd8402,  18'sd50817, 18'sd2471 },
    '{ 18'sd54251, -18'sd49296, -18'sd6265,   18'sd21620, -18'sd31818, 18'sd25657, 18'sd2648 },
    '{ 18'sd65195,  18'sd17400, -18'sd25218,  18'sd27604,  18'sd25736, 18'sd18999, 18'sd3178 },
    '{ 18'sd50122, -18'sd27296, -18'sd31818, -18'sd22059, -18'sd6462,  18'sd47717, 18'sd2444 },
    '{ 18'sd72457,  18'sd49722,  18'sd7727,   18'sd4902,  -18'sd14365, 18'sd9771,  18'sd3532 }
  };

  localparam logic signed [AccW-1:0] SatHi =
    $signed({{(AccW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [AccW-1:0] SatLo =
    $signed({{(AccW-DW+1){1'b1}}, {(DW-1){1'b0}}});

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [AccW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SatHi) begin
      r = SatHi[DW-1:0];
    end else if (v < SatLo) begin
      r = SatLo[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pccms_if.sv =====
// Valid/ready channel interfaces for the reference request and the result.
interface pccms_in_if;
  import pccms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] voltage_ref;
  modport source (output valid, output voltage_ref, input ready);
  modport sink (input valid, input voltage_ref, output ready);
endinterface

interface pccms_out_if;
  import pccms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] output_voltage;
  logic signed [DW-1:0] drive_value;
  modport source (output valid, output output_voltage, output drive_value, input ready);
  modport sink (input valid, input output_voltage, input drive_value, output ready);
endinterface

// ===== hw/rtl/pi_controlled_converter_model_step_unit.sv =====
// Top level: PI controller with anti-windup feeding a six-state converter model.
// Each accepted reference request produces one result (new u3 and the drive): the
// error, the integral update and the drive are formed in turn, the 42 matrix terms run
// through the one shared 32x25 multiplier (one product issued per cycle, accumulated
// in the cycle after), the output step commits the states and loads the output
// register, and the unit returns to idle to take the next request. The input is ready
// only in idle; a finished result waits in the output register while the next request
// is taken, and the unit stalls before loading a new result until the old one is taken.
// Values are signed Q16.16 with saturation; gains are unsigned Q8.16.
module pi_controlled_converter_model_step_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  pccms_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [pccms_pkg::LimW-1:0]       cfg_data_i,
  pccms_in_if.sink                         in_i,
  pccms_out_if.source                      out_o
);
  import pccms_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_KI   = 8'b0000_0100,
    S_INT  = 8'b0000_1000,
    S_REJ  = 8'b0001_0000,
    S_DRV  = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [GainW-1:0] kp_q, ki_q;
  logic [LimW-1:0]  il_q, dl_q;

  logic signed [DW-1:0] ref_q, err_q, integ_q, inew_q, drive_q;
  logic signed [DW-1:0] st_q [NumStates];
  logic signed [DW-1:0] nxt_q [NumStates];
  logic signed [AccW-1:0] acc_q, acc_d;

  logic [IdxW-1:0] row_q, row_d, col_q, col_d, prow_q, pcol_q;
  logic            iss_q, iss_d, pvld_q, pvld_d;
  logic            out_vld_q, out_vld_d, out_load;
  logic signed [DW-1:0] out_v_q, out_dr_q;

  logic                   mul_en;
  logic signed [DW-1:0]   mul_a;
  logic signed [OpBW-1:0] mul_b;
  logic signed [RndW-1:0] rnd;

  logic signed [DW-1:0] err_w, isat_w, iclamp_w, drive_w, lim_w, mag_w;
  logic                 last_term;

  pccms_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (rnd)
  );

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.output_voltage = out_v_q;
  assign out_o.drive_value   = out_dr_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = err_q;
    mul_b  = $signed({1'b0, ki_q});
    mul_en = 1'b0;
    unique case (state_q)
      S_KI: begin
        mul_en = 1'b1;
      end
      S_INT: begin
        mul_en = 1'b1;
        mul_b  = $signed({1'b0, kp_q});
      end
      S_MAC: begin
        mul_en = iss_q;
        if (col_q == DriveCol) begin
          mul_a = drive_q;
        end else begin
          mul_a = st_q[col_q];
        end
        mul_b = OpBW'(COEF[row_q][col_q]);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Controller arithmetic.
  always_comb begin
    err_w  = sat_dw(AccW'(ref_q) - AccW'(st_q[LastRow]));
    isat_w = sat_dw(AccW'(integ_q) + AccW'(rnd));
    lim_w  = $signed({1'b0, il_q});
    if (isat_w > lim_w) begin
      iclamp_w = lim_w;
    end else if (isat_w < -lim_w) begin
      iclamp_w = -lim_w;
    end else begin
      iclamp_w = isat_w;
    end
    mag_w   = inew_q[DW-1] ? -inew_q : inew_q;
    drive_w = sat_dw(AccW'(rnd) + AccW'(integ_q));
  end

  assign last_term = pvld_q && (prow_q == LastRow) && (pcol_q == DriveCol);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    iss_d     = iss_q;
    pvld_d    = 1'b0;
    out_load  = 1'b0;
    acc_d     = ((pcol_q == '0) ? '0 : acc_q) + AccW'(rnd);
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_ERR;
        end
      end
      S_ERR: state_d = S_KI;
      S_KI:  state_d = S_INT;
      S_INT: state_d = S_REJ;
      S_REJ: state_d = S_DRV;
      S_DRV: begin
        state_d = S_MAC;
        row_d   = '0;
        col_d   = '0;
        iss_d   = 1'b1;
      end
      S_MAC: begin
        if (iss_q) begin
          pvld_d = 1'b1;
          if (col_q == DriveCol) begin
            col_d = '0;
            if (row_q == LastRow) begin
              iss_d = 1'b0;
            end else begin
              row_d = row_q + IdxW'(1);
            end
          end else begin
            col_d = col_q + IdxW'(1);
          end
        end
        if (last_term) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_vld_d = (out_vld_q && !out_o.ready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      iss_q     <= 1'b0;
      pvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
      kp_q      <= KpReset;
      ki_q      <= KiReset;
      il_q      <= IlReset;
      dl_q      <= DlReset;
      integ_q   <= '0;
      for (int i = 0; i < NumStates; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      iss_q     <= iss_d;
      pvld_q    <= pvld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgKp:         kp_q <= cfg_data_i[GainW-1:0];
          CfgKi:         ki_q <= cfg_data_i[GainW-1:0];
          CfgIntLimit:   il_q <= cfg_data_i;
          CfgDriveLimit: dl_q <= cfg_data_i;
          default:       kp_q <= kp_q;
        endcase
      end
      // A clamped integral at or beyond the drive limit is rejected.
      if (state_q == S_REJ && $unsigned(mag_w) < {1'b0, dl_q}) begin
        integ_q <= inew_q;
      end
      if (out_load) begin
        for (int i = 0; i < NumStates; i++) begin
          st_q[i] <= nxt_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ref_q <= in_i.voltage_ref;
    end
    if (state_q == S_ERR) begin
      err_q <= err_w;
    end
    if (state_q == S_INT) begin
      inew_q <= iclamp_w;
    end
    if (state_q == S_DRV) begin
      drive_q <= drive_w;
    end
    if (state_q == S_MAC && iss_q) begin
      prow_q <= row_q;
      pcol_q <= col_q;
    end
    if (pvld_q) begin
      acc_q <= acc_d;
      if (pcol_q == DriveCol) begin
        nxt_q[prow_q] <= sat_dw(acc_d);
      end
    end
    if (out_load) begin
      out_v_q  <= nxt_q[LastRow];
      out_dr_q <= drive_q;
    end
  end

  a_accept_to_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_ERR)
    else $error("accepted request did not start the error step");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_OUT)
    else $error("result became valid outside the output step");

  a_mac_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC && !iss_q |-> pvld_q)
    else $error("matrix pass stalled with no product pending");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !iss_q && !pvld_q)
    else $error("ready while the matrix pass is still running");

endmodule

// ===== hw/rtl/pccms_mul.sv =====
// Shared signed multiplier with product register and round-to-nearest back to Q.16.
module pccms_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [pccms_pkg::DW-1:0]     a_i,
  input  logic signed [pccms_pkg::OpBW-1:0]   b_i,
  output logic signed [pccms_pkg::RndW-1:0]   rnd_o
);
  import pccms_pkg::*;

  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) <<< (FracBits - 1);

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] biased;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Adding half an LSB and dropping the fraction rounds ties toward +infinity.
  assign biased = prod_q + RndHalf;
  assign rnd_o  = biased[ProdW-1:FracBits];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the PI-controlled converter model step unit.
module tb;
  import pccms_pkg::*;

  localparam int     LatencyCycles = 60;
  localparam int     CycleLimit    = 400000;
  localparam int     BlockItems    = 40;
  localparam int     PhaseBlocks   = 4;
  localparam longint DataMax       = 64'sd2147483647;
  localparam longint DataMin       = -64'sd2147483648;
  localparam longint GainMax       = 64'sd16777215;
  localparam longint LimitMax      = 64'sd2147483647;

  typedef struct packed {
    logic signed [DW-1:0] output_voltage;
    logic signed [DW-1:0] drive_value;
  } step_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [LimW-1:0]     cfg_data_i;

  pccms_in_if  ref_ch ();
  pccms_out_if res_ch ();

  pi_controlled_converter_model_step_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (ref_ch),
    .out_o      (res_ch)
  );

  // Converter matrix in Q2.16; columns are i1, u1, i2, u2, i3, u3 and the drive.
  int plant_coef [6][7] = '{
    '{ 63255,  -1127,    374,   -380,    341,  -1645, 3087 },
    '{ 50672,   8205,  15172,   4588,   8402,  50817, 2471 },
    '{ 54251, -49296,  -6265,  21620, -31818,  25657, 2648 },
    '{ 65195,  17400, -25218,  27604,  25736,  18999, 3178 },
    '{ 50122, -27296, -31818, -22059,  -6462,  47717, 2444 },
    '{ 72457,  49722,   7727,   4902, -14365,   9771, 3532 }
  };

  longint       kp_gain;
  longint       ki_gain;
  longint       integ_limit;
  longint       drive_lim;
  longint       integ_acc;
  longint       plant_x [6];
  step_result_t expected_steps [$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 28;
  int           recv_idle_pct  = 63;
  int           cycle_count    = 0;

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_dw(input longint v);
    if (v > DataMax) begin
      return DataMax;
    end else if (v < DataMin) begin
      return DataMin;
    end
    return v;
  endfunction

  // Product with a Q.16 factor, rounded to nearest with ties going up.
  function automatic longint scale_q16(input longint v, input longint c);
    longint hi;
    longint lo;
    hi = v >>> FracBits;
    lo = v - (hi <<< FracBits);
    return hi * c + ((lo * c + (64'sd1 <<< (FracBits - 1))) >>> FracBits);
  endfunction

  function automatic step_result_t predict_step(input logic signed [DW-1:0] vref);
    longint       err;
    longint       integ;
    longint       mag;
    longint       drv;
    longint       acc;
    longint       nx [6];
    step_result_t res;
    err = clamp_dw(longint'(vref) - plant_x[5]);
    integ = clamp_dw(integ_acc + scale_q16(err, ki_gain));
    if (integ > integ_limit) begin
      integ = integ_limit;
    end else if (integ < -integ_limit) begin
      integ = -integ_limit;
    end
    mag = (integ < 0) ? -integ : integ;
    // An integral that reaches the drive limit is thrown away.
    if (mag >= drive_lim) begin
      integ = integ_acc;
    end
    integ_acc = integ;
    drv = clamp_dw(scale_q16(err, kp_gain) + integ);
    for (int row = 0; row < 6; row++) begin
      acc = scale_q16(drv, plant_coef[row][6]);
      for (int col = 0; col < 6; col++) begin
        acc += scale_q16(plant_x[col], plant_coef[row][col]);
      end
      nx[row] = clamp_dw(acc);
    end
    for (int row = 0; row < 6; row++) begin
      plant_x[row] = nx[row];
    end
    res.output_voltage = plant_x[5][DW-1:0];
    res.drive_value    = drv[DW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Leaves we high; the caller lowers it after the last register.
  task automatic write_reg(input cfg_idx_e idx, input longint value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[LimW-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_gains(input longint kp, input longint ki, input longint il,
                           input longint dl);
    write_reg(CfgKp, kp);
    write_reg(CfgKi, ki);
    write_reg(CfgIntLimit, il);
    write_reg(CfgDriveLimit, dl);
    cfg_we_i    <= 1'b0;
    kp_gain     = kp;
    ki_gain     = ki;
    integ_limit = il;
    drive_lim   = dl;
  endtask

  // Valid stays high on return so that back-to-back requests need no extra edge.
  task automatic send_ref(input logic signed [DW-1:0] vref);
    while ($urandom_range(99) < send_idle_pct) begin
      ref_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ref_ch.valid       <= 1'b1;
    ref_ch.voltage_ref <= vref;
    @(posedge clk_i);
    while (!ref_ch.ready) begin
      @(posedge clk_i);
    end
    expected_steps.push_back(predict_step(vref));
  endtask

  task automatic drain_results();
    ref_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic longint rand_gain();
    case ($urandom_range(3))
      0:       return longint'($urandom_range(GainMax));
      1:       return longint'($urandom_range(262144));
      2:       return ($urandom_range(1) != 0) ? GainMax : 64'sd0;
      default: return longint'($urandom_range(65536));
    endcase
  endfunction

  function automatic longint rand_limit();
    case ($urandom_range(3))
      0:       return longint'($urandom_range(LimitMax));
      1:       return longint'($urandom_range(6553600));
      2:       return ($urandom_range(1) != 0) ? LimitMax : 64'sd0;
      default: return longint'($urandom_range(1048576));
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_ref();
    longint v;
    case ($urandom_range(9))
      6, 7:    v = longint'($signed($urandom()));
      8:       v = ($urandom_range(1) != 0) ? DataMax : DataMin;
      9:       v = longint'($urandom_range(15)) - 8;
      default: v = longint'($urandom_range(2621440)) - 1310720;
    endcase
    return v[DW-1:0];
  endfunction

  task automatic test_reset_gains();
    send_ref(32'sh0000_0000);
    send_ref(32'sh0005_0000);
    send_ref(32'sh0005_0000);
    send_ref(-32'sh0005_0000);
    send_ref(32'sh7FFF_FFFF);
    send_ref(32'sh8000_0000);
    send_ref(-32'sd1);
    send_ref(32'sd1);
    drain_results();
  endtask

  task automatic test_full_scale_gains();
    set_gains(GainMax, GainMax, LimitMax, LimitMax);
    send_ref(32'sh7FFF_FFFF);
    send_ref(32'sh8000_0000);
    send_ref(32'sh7FFF_FFFF);
    send_ref(32'sh8000_0000);
    send_ref(32'sh0000_0000);
    drain_results();
  endtask

  task automatic test_frozen_integrator();
    // A zero drive limit rejects every integral update.
    set_gains(64'sd65536, 64'sd6554, 64'sd655360, 64'sd0);
    send_ref(32'sh000A_0000);
    send_ref(-32'sh000A_0000);
    send_ref(32'sh000A_0000);
    drain_results();
    set_gains(64'sd0, GainMax, 64'sd0, LimitMax);
    send_ref(32'sh0010_0000);
    send_ref(-32'sh0010_0000);
    drain_results();
  endtask

  task automatic test_integral_clamp();
    // Limit below the rejection level, so the integral sits on the clamp.
    set_gains(64'sd65536, 64'sd1048576, 64'sd65536, 64'sd1048576);
    send_ref(32'sh0020_0000);
    send_ref(-32'sh0020_0000);
    drain_results();
    // Rejection level below the clamp, so large updates are discarded.
    set_gains(64'sd65536, 64'sd1048576, 64'sd4194304, 64'sd262144);
    send_ref(32'sh0020_0000);
    send_ref(-32'sh0001_0000);
    drain_results();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input bit with_pause);
    logic signed [DW-1:0] setpoint;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int blk = 0; blk < PhaseBlocks; blk++) begin
      set_gains(rand_gain(), rand_gain(), rand_limit(), rand_limit());
      setpoint = rand_ref();
      for (int n = 0; n < BlockItems; n++) begin
        // Mostly held setpoints so the loop can settle, with steps in between.
        if ($urandom_range(4) == 0) begin
          setpoint = rand_ref();
        end
        send_ref(setpoint);
        if (with_pause && blk == 1 && n == BlockItems / 2) begin
          drain_results();
        end
      end
      drain_results();
    end
  endtask

  task automatic test_random_refs();
    run_random_phase(28, 63, 1'b1);
    run_random_phase(63, 28, 1'b0);
    run_random_phase(0, 0, 1'b0);
  endtask

  always @(posedge clk_i) begin : check_results
    step_result_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch($sformatf("unexpected result u3=%0d drive=%0d",
                                  res_ch.output_voltage, res_ch.drive_value));
      end else begin
        want = expected_steps.pop_front();
        if (res_ch.output_voltage !== want.output_voltage) begin
          report_mismatch($sformatf("output_voltage got %0d want %0d",
                                    res_ch.output_voltage, want.output_voltage));
        end
        if (res_ch.drive_value !== want.drive_value) begin
          report_mismatch($sformatf("drive_value got %0d want %0d",
                                    res_ch.drive_value, want.drive_value));
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("pi_controlled_converter_model_step_unit regression: fail");
    $finish;
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgKp;
    cfg_data_i         <= '0;
    ref_ch.valid       <= 1'b0;
    ref_ch.voltage_ref <= '0;
    kp_gain     = 64'sd65536;
    ki_gain     = 64'sd6554;
    integ_limit = 64'sd655360;
    drive_lim   = 64'sd655360;
    integ_acc   = 0;
    for (int k = 0; k < 6; k++) begin
      plant_x[k] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_gains();
    test_full_scale_gains();
    test_frozen_integrator();
    test_integral_clamp();
    test_random_refs();

    drain_results();
    repeat (LatencyCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("pi_controlled_converter_model_step_unit regression: pass");
    end else begin
      $display("pi_controlled_converter_model_step_unit regression: fail");
    end
    $finish;
  end

endmodule
